FILE: rtl/tcch_pkg.sv
`timescale 1ns / 1ps
package tcch_pkg;

  // CORDIC iteration count, 8..24
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 5;          // counter wide enough for up to 24 steps
  localparam int XW = 58;             // CORDIC x/y datapath
  localparam int ZW = 34;             // CORDIC angle datapath, 2^32 per turn
  localparam int MA_W = 36;           // shared multiplier operand A
  localparam int MB_W = 25;           // shared multiplier operand B
  localparam int P_W = MA_W + MB_W;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 58'sd652032874;
  localparam logic signed [15:0] DECL_RESET = 16'sd600;
  localparam logic [15:0] SCALE_ONE = 16'd4096;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CAL   = 2'd1,
    OP_HEAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_REC_START, ST_REC_AX, ST_REC_WAIT,
    ST_H_A0, ST_H_A1, ST_H_A2, ST_H_A3,
    ST_SC0, ST_SC1, ST_SC2, ST_SC3, ST_SCW,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
    ST_VW, ST_C1, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic vec;      // 1 vectoring (atan2), 0 rotation (sin/cos)
  } cordic_ctl_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10680862;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670675;
      5'd9:  v = 34'sd1335343;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // negate, most negative word saturates
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == -16'sd32768) r = 16'sd32767;
    else r = -v;
    return r;
  endfunction

endpackage

FILE: rtl/tilt_compensated_compass_heading.sv
`timescale 1ns / 1ps
// Start and no-op transactions go from accept straight to the result; calibration
// recomputes each axis in turn on the 16-step quotient unit (a zero-range axis skips it).
// Heading runs the shared CORDIC 3 times: roll, pitch, then vectoring.
// One transaction at a time; the next can be accepted from the cycle out_valid rises.
// Reset (rst_n low, synchronous): bounds and offsets zero, scales one (4096), status 0,
// declination 600 centidegrees, no result pending.
module tilt_compensated_compass_heading import tcch_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_mag_x,
  input  logic signed [15:0] in_mag_y,
  input  logic signed [15:0] in_mag_z,
  input  logic signed [15:0] in_roll_centideg,
  input  logic signed [15:0] in_pitch_centideg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_heading_centideg,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);

  state_t state_r, state_nxt;
  logic   acc;

  // calibration state
  logic signed [15:0] min_r [3];
  logic signed [15:0] max_r [3];
  logic signed [16:0] off_r [3];
  logic [15:0]        scale_r [3];
  logic               deg_r;
  logic signed [15:0] decl_r;

  // transaction payload
  op_t                op_r;
  logic signed [15:0] v_r [3];
  logic signed [15:0] roll_r, pitch_r;
  logic signed [15:0] vin [3];

  // recomputation
  logic [1:0]  k_r;
  logic [16:0] rng_r [3];
  logic [18:0] total_r;
  logic [17:0] den;
  logic [30:0] num;
  logic        div_start, div_done;
  logic [15:0] div_quo;

  // heading datapath
  logic signed [20:0] a_r [3];
  logic signed [17:0] dif [3];
  logic [13:0]        n_r;
  logic               neg_r, flip_r, sel_r;
  logic [30:0]        t1_r;
  logic signed [17:0] sr_r, cr_r, sp_r, cp_r;
  logic signed [35:0] ps_r, cs_r;
  logic signed [55:0] hx_r, hy_r;
  logic               vzero_r;
  logic [15:0]        hd_r;

  // shared multiplier
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [P_W-1:0]  prod_r;

  // shared CORDIC
  cordic_ctl_t          cctl;
  logic signed [XW-1:0] cx0, cy0, cx_r, cy_r;
  logic signed [ZW-1:0] cz0, cz_r;
  logic                 c_done;

  // angle reduction to [-90, 90] degrees
  logic signed [15:0] ang_in;
  logic signed [16:0] red1, red2;
  logic               red_flip;
  logic [13:0]        red_n;
  logic signed [ZW-1:0] zrot;

  // vectoring fold and final wrap
  logic signed [55:0]   hyd;
  logic signed [XW-1:0] xin, yin;
  logic signed [ZW-1:0] ang;
  logic signed [P_W-1:0] rsum;
  logic signed [17:0]   hsum, hwrap;
  logic signed [XW-1:0] xf, yf;
  logic                 out_free;

  assign acc       = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign vin[0] = neg_sat(in_mag_x);
  assign vin[1] = neg_sat(in_mag_y);
  assign vin[2] = neg_sat(in_mag_z);

  // twice the sample minus twice the mid-range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = {v_r[k][15], v_r[k], 1'b0} - {off_r[k][16], off_r[k]};
    end
  end

  assign den = {1'b0, rng_r[k_r]} + {rng_r[k_r], 1'b0};
  assign num = {total_r, 12'h000} + {13'h0000, den[17:1]};

  always_comb begin
    ang_in = sel_r ? pitch_r : roll_r;
    red1 = {ang_in[15], ang_in};
    if (red1 >= 17'sd18000) red1 = red1 - 17'sd36000;
    else if (red1 < -17'sd18000) red1 = red1 + 17'sd36000;
    red2 = red1;
    red_flip = 1'b0;
    if (red1 > 17'sd9000) begin
      red2 = red1 - 17'sd18000;
      red_flip = 1'b1;
    end else if (red1 < -17'sd9000) begin
      red2 = red1 + 17'sd18000;
      red_flip = 1'b1;
    end
    red_n = red2[16] ? 14'(-red2) : red2[13:0];
  end

  // turn fraction: n * 2^32 / 36000 = n * 119304 + n * 728 / 1125;
  // the last quotient is prod * ceil(2^34 / 1125) >> 34
  always_comb begin
    zrot = ZW'({1'b0, t1_r}) + ZW'({1'b0, prod_r[46:34]});
    if (neg_r) zrot = -zrot;
  end

  assign hyd = hy_r - prod_r[55:0];
  assign xin = {hyd[42:0], 15'h0000};
  assign yin = XW'(hx_r);
  assign ang = vzero_r ? '0 : cz_r;
  assign xf  = flip_r ? -cx_r : cx_r;
  assign yf  = flip_r ? -cy_r : cy_r;

  // round half up to centidegrees, add declination, wrap to one turn
  always_comb begin
    rsum = prod_r + P_W'(64'sd2147483648);
    hsum = 18'($signed(rsum[48:32])) + 18'(decl_r);
    if (hsum < -18'sd36000) hwrap = hsum + 18'sd72000;
    else if (hsum < 18'sd0) hwrap = hsum + 18'sd36000;
    else if (hsum >= 18'sd36000) hwrap = hsum - 18'sd36000;
    else hwrap = hsum;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (op_t'(in_operation))
            OP_CAL:  state_nxt = ST_REC_START;
            OP_HEAD: state_nxt = ST_H_A0;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_REC_START: state_nxt = ST_REC_AX;
      ST_REC_AX: begin
        if (rng_r[k_r] != '0) state_nxt = ST_REC_WAIT;
        else if (k_r == 2'd2) state_nxt = ST_DONE;
      end
      ST_REC_WAIT: begin
        if (div_done) state_nxt = (k_r == 2'd2) ? ST_DONE : ST_REC_AX;
      end
      ST_H_A0: state_nxt = ST_H_A1;
      ST_H_A1: state_nxt = ST_H_A2;
      ST_H_A2: state_nxt = ST_H_A3;
      ST_H_A3: state_nxt = ST_SC0;
      ST_SC0:  state_nxt = ST_SC1;
      ST_SC1:  state_nxt = ST_SC2;
      ST_SC2:  state_nxt = ST_SC3;
      ST_SC3:  state_nxt = ST_SCW;
      ST_SCW: begin
        if (c_done) state_nxt = sel_r ? ST_M0 : ST_SC0;
      end
      ST_M0: state_nxt = ST_M1;
      ST_M1: state_nxt = ST_M2;
      ST_M2: state_nxt = ST_M3;
      ST_M3: state_nxt = ST_M4;
      ST_M4: state_nxt = ST_M5;
      ST_M5: state_nxt = ST_M6;
      ST_M6: state_nxt = ST_M7;
      ST_M7: state_nxt = ST_VW;
      ST_VW: begin
        if (c_done) state_nxt = ST_C1;
      end
      ST_C1: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit controls and multiplier operands
  always_comb begin
    ma        = '0;
    mb        = '0;
    cctl      = '0;
    cx0       = CORDIC_GAIN;
    cy0       = '0;
    cz0       = zrot;
    div_start = 1'b0;
    case (state_r)
      ST_REC_AX: div_start = (rng_r[k_r] != '0);
      ST_H_A0: begin
        ma = MA_W'(dif[0]);
        mb = MB_W'({1'b0, scale_r[0]});
      end
      ST_H_A1: begin
        ma = MA_W'(dif[1]);
        mb = MB_W'({1'b0, scale_r[1]});
      end
      ST_H_A2: begin
        ma = MA_W'(dif[2]);
        mb = MB_W'({1'b0, scale_r[2]});
      end
      ST_SC0: begin
        ma = MA_W'({1'b0, red_n});
        mb = 25'sd119304;
      end
      ST_SC1: begin
        ma = MA_W'({1'b0, n_r});
        mb = 25'sd728;
      end
      ST_SC2: begin
        ma = MA_W'({1'b0, prod_r[22:0]});
        mb = 25'sd15270995;
      end
      ST_SC3: cctl.start = 1'b1;
      ST_M0: begin
        ma = MA_W'(sp_r);
        mb = MB_W'(sr_r);
      end
      ST_M1: begin
        ma = MA_W'(cp_r);
        mb = MB_W'(sr_r);
      end
      ST_M2: begin
        ma = ps_r;
        mb = MB_W'(a_r[1]);
      end
      ST_M3: begin
        ma = cs_r;
        mb = MB_W'(a_r[2]);
      end
      ST_M4: begin
        ma = MA_W'(cr_r);
        mb = MB_W'(a_r[0]);
      end
      ST_M5: begin
        ma = MA_W'(cp_r);
        mb = MB_W'(a_r[1]);
      end
      ST_M6: begin
        ma = MA_W'(sp_r);
        mb = MB_W'(a_r[2]);
      end
      ST_M7: begin
        // left half plane: mirror into the right one and start from +/- half a turn
        cctl.start = 1'b1;
        cctl.vec   = 1'b1;
        cx0 = xin[XW-1] ? -xin : xin;
        cy0 = xin[XW-1] ? -yin : yin;
        if (!xin[XW-1]) cz0 = '0;
        else if (!yin[XW-1]) cz0 = 34'sd2147483648;
        else cz0 = -34'sd2147483648;
      end
      ST_VW: begin
        ma = MA_W'(ang);
        mb = 25'sd36000;
      end
      default: ;
    endcase
  end

  // control and calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      decl_r    <= DECL_RESET;
      deg_r     <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        min_r[k]   <= '0;
        max_r[k]   <= '0;
        off_r[k]   <= '0;
        scale_r[k] <= SCALE_ONE;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) decl_r <= cfg_data;
      if (state_r == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (acc && op_t'(in_operation) == OP_START) begin
        for (int k = 0; k < 3; k++) begin
          min_r[k] <= vin[k];
          max_r[k] <= vin[k];
        end
      end
      if (acc && op_t'(in_operation) == OP_CAL) begin
        for (int k = 0; k < 3; k++) begin
          if (vin[k] < min_r[k]) min_r[k] <= vin[k];
          if (vin[k] > max_r[k]) max_r[k] <= vin[k];
        end
      end
      if (state_r == ST_REC_START) begin
        deg_r <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          off_r[k] <= 17'(max_r[k]) + 17'(min_r[k]);
        end
      end
      if (state_r == ST_REC_AX && rng_r[k_r] == '0) begin
        scale_r[k_r] <= SCALE_ONE;
        deg_r        <= 1'b1;
      end
      if (state_r == ST_REC_WAIT && div_done) scale_r[k_r] <= div_quo;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r    <= op_t'(in_operation);
      v_r     <= vin;
      roll_r  <= in_roll_centideg;
      pitch_r <= in_pitch_centideg;
      hd_r    <= '0;
      sel_r   <= 1'b0;
    end
    case (state_r)
      ST_REC_START: begin
        k_r <= '0;
        for (int k = 0; k < 3; k++) begin
          rng_r[k] <= 17'(max_r[k]) - 17'(min_r[k]);
        end
        total_r <= 19'(17'(max_r[0]) - 17'(min_r[0])) + 19'(17'(max_r[1]) - 17'(min_r[1]))
                   + 19'(17'(max_r[2]) - 17'(min_r[2]));
      end
      ST_REC_AX: begin
        if (rng_r[k_r] == '0) k_r <= k_r + 2'd1;
      end
      ST_REC_WAIT: begin
        if (div_done) k_r <= k_r + 2'd1;
      end
      ST_H_A1: a_r[0] <= prod_r[33:13];
      ST_H_A2: a_r[1] <= prod_r[33:13];
      ST_H_A3: a_r[2] <= prod_r[33:13];
      ST_SC0: begin
        n_r    <= red_n;
        neg_r  <= red2[16];
        flip_r <= red_flip;
      end
      ST_SC1: t1_r <= prod_r[30:0];
      ST_SCW: begin
        if (c_done) begin
          sel_r <= 1'b1;
          if (sel_r) begin
            cp_r <= xf[32:15];
            sp_r <= yf[32:15];
          end else begin
            cr_r <= xf[32:15];
            sr_r <= yf[32:15];
          end
        end
      end
      ST_M1: ps_r <= prod_r[35:0];
      ST_M2: cs_r <= prod_r[35:0];
      ST_M3: hx_r <= prod_r[55:0];
      ST_M4: hx_r <= hx_r - prod_r[55:0];
      ST_M5: hx_r <= hx_r + {prod_r[40:0], 15'h0000};
      ST_M6: hy_r <= prod_r[55:0];
      ST_M7: vzero_r <= (xin == '0) && (yin == '0);
      ST_C1: hd_r <= hwrap[15:0];
      ST_DONE: begin
        if (out_free) begin
          out_heading_centideg <= hd_r;
          out_status           <= deg_r;
        end
      end
      default: ;
    endcase
  end

  tcch_mul u_mul (
    .clk    (clk),
    .a      (ma),
    .b      (mb),
    .prod_r (prod_r)
  );

  tcch_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num),
    .den    (den),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  tcch_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cctl),
    .x0     (cx0),
    .y0     (cy0),
    .z0     (cz0),
    .done_r (c_done),
    .x_r    (cx_r),
    .y_r    (cy_r),
    .z_r    (cz_r)
  );

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading_centideg < 16'd36000)
    else $error("heading out of range");

  a_cal_heading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free && op_r != OP_HEAD) |=> out_heading_centideg == 16'd0)
    else $error("non-heading transaction with nonzero heading");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    scale_r[0] != 16'd0 && scale_r[1] != 16'd0 && scale_r[2] != 16'd0)
    else $error("zero soft-iron scale");

  a_div_only_in_rec: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_REC_WAIT)
    else $error("quotient done outside recomputation");

  a_cordic_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cctl.start |=> !c_done)
    else $error("CORDIC finished too early");
`endif

endmodule

FILE: rtl/tcch_mul.sv
`timescale 1ns / 1ps
module tcch_mul import tcch_pkg::*; (
  input  logic                   clk,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [P_W-1:0]  prod_r
);

  // registered signed product, one per cycle
  always_ff @(posedge clk) begin
    prod_r <= P_W'(a) * P_W'(b);
  end

endmodule

FILE: rtl/tcch_div.sv
`timescale 1ns / 1ps
module tcch_div import tcch_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] num,
  input  logic [17:0] den,
  output logic        done_r,
  output logic [15:0] quo_r
);

  logic        busy_r;
  logic [3:0]  cnt_r;
  logic [30:0] rem_r;
  logic [32:0] ds_r;
  logic        fits;

  assign fits = {2'b00, rem_r} >= ds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // quotient beyond 16 bits saturates right away
        if ({3'b000, num} >= {den, 16'h0000}) done_r <= 1'b1;
        else busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 4'd15) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      ds_r  <= {den, 15'h0000};
      cnt_r <= '0;
      quo_r <= 16'hFFFF;
    end else if (busy_r) begin
      if (fits) rem_r <= rem_r - ds_r[30:0];
      quo_r <= {(cnt_r == 4'd0) ? 15'h0000 : quo_r[14:0], fits};
      ds_r  <= ds_r >> 1;
      cnt_r <= cnt_r + 4'd1;
    end
  end

endmodule

FILE: rtl/tcch_cordic.sv
`timescale 1ns / 1ps
module tcch_cordic import tcch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_ctl_t          ctl,
  input  logic signed [XW-1:0] x0,
  input  logic signed [XW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 done_r,
  output logic signed [XW-1:0] x_r,
  output logic signed [XW-1:0] y_r,
  output logic signed [ZW-1:0] z_r
);

  logic              busy_r;
  logic              vec_r;
  logic [STEP_W-1:0] i_r;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic              up;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = atan_entry(i_r);
  // rotate toward z = 0, or toward y = 0 when vectoring
  assign up = vec_r ? y_r[XW-1] : !z_r[ZW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= ctl.vec;
      i_r   <= '0;
    end else if (busy_r) begin
      if (up) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      i_r <= i_r + STEP_W'(1);
    end
  end

endmodule
